// ----- rtl/core/assert_macros.svh -----
// assert_macros.svh: assertion shorthands for the percent encoder checker.
// No dependencies; included by files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define UPE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define UPE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/upe_pkg.sv -----
// upe_pkg.sv: shared types, constants and helpers of the percent encoder.
// No dependencies.
package upe_pkg;

    localparam int LEN_WIDTH = 16;
    localparam logic [32:0] LEN_MAX = 33'((64'd1 << LEN_WIDTH) - 64'd1);

    localparam int CAP_WIDTH  = 16;
    localparam int CFG_WIDTH  = 16;
    localparam int CFG_IDX_W  = 2;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_URL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASURE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd2;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_NO_SPACE = 2'd2,
        ST_TRUNC    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        EMIT_NONE = 2'd0,
        EMIT_LIT  = 2'd1,
        EMIT_ESC  = 2'd2
    } t_emit;

    // one queued job: optional character output, then optional closing item
    typedef struct packed {
        logic [7:0]  data;
        t_emit       emit;
        logic        tail;
        logic [15:0] req;
        t_status     status;
    } t_job;

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        return (v < 4'd10) ? (8'h30 + 8'(v)) : (8'h37 + 8'(v));
    endfunction

endpackage

// ----- rtl/core/utf8_percent_encoder.sv -----
// UTF-8 percent encoder. Bytes of a string enter one per transaction on the
// input channel; results leave one per transaction on the output channel. A
// kept ASCII character yields one result, every other byte yields '%' and two
// uppercase hex digits, and the byte flagged last adds a closing result (char
// 0, last set; in measure mode it carries the required length including the
// terminator, saturating at 65535). An invalid lead byte, lack of space or a
// truncated sequence yields a single closing result with the status code and
// the rest of that string is dropped. Rate: the front accepts one byte per
// cycle while its two-entry job queue has room; the back emits one result per
// cycle while the output is not stalled. The back's single output register
// sets the sustained rate. Configuration is written through a plain write
// port; the user must write it only while the block is idle, which the block
// itself does not enforce. Synchronous active-low reset.
// Depends on upe_pkg, upe_front, upe_queue, upe_back.
module utf8_percent_encoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [upe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [upe_pkg::CFG_WIDTH-1:0]  i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [7:0]                     i_in_byte,
    input  logic                           i_is_last,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [7:0]                     o_out_char,
    output logic [15:0]                    o_required_length,
    output logic [1:0]                     o_status,
    output logic                           o_last
);

    // front -> queue -> back
    logic          q_full;
    logic          q_valid;
    logic          push;
    logic          pop;
    logic          accept;
    upe_pkg::t_job job_in;
    upe_pkg::t_job job_out;

    // a transaction is taken whenever the queue has a free slot
    assign o_in_ready = !q_full;
    assign accept     = i_in_valid && o_in_ready;

    upe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_in_byte   (i_in_byte),
        .i_is_last   (i_is_last),
        .o_push      (push),
        .o_job       (job_in)
    );

    upe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (job_out)
    );

    upe_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_job_valid       (q_valid),
        .i_job             (job_out),
        .o_pop             (pop),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_out_char        (o_out_char),
        .o_required_length (o_required_length),
        .o_status          (o_status),
        .o_last            (o_last)
    );

endmodule

// ----- rtl/core/upe_front.sv -----
// upe_front.sv: accepts input bytes, classifies UTF-8 leads, tracks capacity
// and length, and issues jobs. Depends on upe_pkg.
module upe_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [upe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [upe_pkg::CFG_WIDTH-1:0]  i_cfg_data,
    input  logic                           i_accept,
    input  logic [7:0]                     i_in_byte,
    input  logic                           i_is_last,
    output logic                           o_push,
    output upe_pkg::t_job                  o_job
);

    logic                            r_keep_url, n_keep_url;
    logic                            r_measure, n_measure;
    logic [upe_pkg::CAP_WIDTH-1:0]   r_cap, n_cap;
    logic [1:0]                      r_pend, n_pend;
    logic [upe_pkg::CAP_WIDTH-1:0]   r_rem, n_rem;
    logic [upe_pkg::LEN_WIDTH-1:0]   r_cnt, n_cnt;
    logic                            r_err, n_err;
    logic                            r_started, n_started;

    function automatic logic is_kept(input logic [7:0] b, input logic url);
        logic k;
        k = (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a) ||
            (b >= 8'h30 && b <= 8'h39) ||
            b == 8'h2d || b == 8'h2e || b == 8'h5f || b == 8'h7e;
        if (url && (b == 8'h3a || b == 8'h3d || b == 8'h5b || b == 8'h5d ||
                    b == 8'h3f || b == 8'h26 || b == 8'h25))
            k = 1'b1;
        return k;
    endfunction

    logic [2:0]  lead_n;
    logic        keep;
    logic [3:0]  hex;
    logic        fail;
    upe_pkg::t_status code;
    upe_pkg::t_emit   emit;
    logic        end_str;
    logic [32:0] sum;
    logic [32:0] tot;
    logic [upe_pkg::LEN_WIDTH-1:0] cnt_new;
    logic [15:0] req;

    always_comb begin
        // lead byte classification: 0 means invalid
        priority if (i_in_byte[7] == 1'b0)          lead_n = 3'd1;
        else if (i_in_byte[7:5] == 3'b110)          lead_n = 3'd2;
        else if (i_in_byte[7:4] == 4'b1110)         lead_n = 3'd3;
        else if (i_in_byte[7:3] == 5'b11110)        lead_n = 3'd4;
        else                                        lead_n = 3'd0;

        keep = (lead_n == 3'd1) && is_kept(i_in_byte, r_keep_url);
        unique case (lead_n)
            3'd1:    hex = keep ? 4'd1 : 4'd3;
            3'd2:    hex = 4'd6;
            3'd3:    hex = 4'd9;
            3'd4:    hex = 4'd12;
            default: hex = 4'd0;
        endcase

        // saturating length accumulation
        sum = 33'(r_cnt) + 33'(hex);
        cnt_new = (sum > upe_pkg::LEN_MAX) ? upe_pkg::LEN_WIDTH'(upe_pkg::LEN_MAX)
                                           : upe_pkg::LEN_WIDTH'(sum);

        n_keep_url = r_keep_url;
        n_measure  = r_measure;
        n_cap      = r_cap;
        n_pend     = r_pend;
        n_rem      = r_rem;
        n_cnt      = r_cnt;
        n_err      = r_err;
        n_started  = r_started;

        fail    = 1'b0;
        code    = upe_pkg::ST_OK;
        emit    = upe_pkg::EMIT_NONE;
        end_str = 1'b0;
        o_push  = 1'b0;

        if (i_accept && !r_err) begin
            n_started = 1'b1;
            if (r_pend == 2'd0) begin
                if (lead_n == 3'd0) begin
                    fail = 1'b1;
                    code = upe_pkg::ST_INVALID;
                end else if (!r_measure && {12'd0, hex} >= r_rem) begin
                    fail = 1'b1;
                    code = upe_pkg::ST_NO_SPACE;
                end else if (lead_n != 3'd1 && i_is_last) begin
                    fail = 1'b1;
                    code = upe_pkg::ST_TRUNC;
                end else begin
                    if (r_measure) begin
                        n_cnt = cnt_new;
                    end else begin
                        n_rem = r_rem - upe_pkg::CAP_WIDTH'(hex);
                        emit  = keep ? upe_pkg::EMIT_LIT : upe_pkg::EMIT_ESC;
                    end
                    n_pend = 2'(lead_n - 3'd1);
                end
            end else begin
                n_pend = r_pend - 2'd1;
                if (n_pend != 2'd0 && i_is_last) begin
                    fail = 1'b1;
                    code = upe_pkg::ST_TRUNC;
                end else if (!r_measure) begin
                    emit = upe_pkg::EMIT_ESC;
                end
            end
        end

        // closing length: count after this byte, plus terminator
        tot = 33'(n_cnt) + 33'd1;
        if (tot > upe_pkg::LEN_MAX)
            tot = upe_pkg::LEN_MAX;
        req = (tot > 33'h0ffff) ? 16'hffff : 16'(tot);

        o_job.data   = i_in_byte;
        o_job.emit   = emit;
        o_job.tail   = 1'b0;
        o_job.req    = 16'd0;
        o_job.status = upe_pkg::ST_OK;

        if (i_accept) begin
            if (r_err) begin
                end_str = i_is_last;
            end else if (fail) begin
                o_job.emit   = upe_pkg::EMIT_NONE;
                o_job.tail   = 1'b1;
                o_job.status = code;
                o_push       = 1'b1;
                n_err        = 1'b1;
                end_str      = i_is_last;
            end else begin
                o_job.tail = i_is_last;
                o_job.req  = (i_is_last && r_measure) ? req : 16'd0;
                o_push     = i_is_last || (emit != upe_pkg::EMIT_NONE);
                end_str    = i_is_last;
            end
        end

        if (end_str) begin
            n_pend    = 2'd0;
            n_rem     = r_cap;
            n_cnt     = '0;
            n_err     = 1'b0;
            n_started = 1'b0;
        end

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                upe_pkg::CFG_KEEP_URL: n_keep_url = i_cfg_data[0];
                upe_pkg::CFG_MEASURE:  n_measure  = i_cfg_data[0];
                upe_pkg::CFG_CAPACITY: begin
                    n_cap = i_cfg_data[upe_pkg::CAP_WIDTH-1:0];
                    if (!r_started)
                        n_rem = i_cfg_data[upe_pkg::CAP_WIDTH-1:0];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_url <= 1'b0;
            r_measure  <= 1'b0;
            r_cap      <= '1;
            r_pend     <= 2'd0;
            r_rem      <= '1;
            r_cnt      <= '0;
            r_err      <= 1'b0;
            r_started  <= 1'b0;
        end else begin
            r_keep_url <= n_keep_url;
            r_measure  <= n_measure;
            r_cap      <= n_cap;
            r_pend     <= n_pend;
            r_rem      <= n_rem;
            r_cnt      <= n_cnt;
            r_err      <= n_err;
            r_started  <= n_started;
        end
    end

endmodule

// ----- rtl/core/upe_queue.sv -----
// upe_queue.sv: short job queue between front and back.
// Depends on upe_pkg.
module upe_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  upe_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output upe_pkg::t_job o_job
);

    upe_pkg::t_job                 r_mem [upe_pkg::QDEPTH];
    logic [upe_pkg::QPTR_W-1:0]    r_wr, n_wr;
    logic [upe_pkg::QPTR_W-1:0]    r_rd, n_rd;
    logic [upe_pkg::QCNT_W-1:0]    r_cnt, n_cnt;

    function automatic logic [upe_pkg::QPTR_W-1:0] bump(input logic [upe_pkg::QPTR_W-1:0] p);
        return (32'(p) == upe_pkg::QDEPTH - 1) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (32'(r_cnt) == upe_pkg::QDEPTH);
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = bump(r_wr);
        end
        if (i_pop) begin
            n_rd = bump(r_rd);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// ----- rtl/core/upe_back.sv -----
// upe_back.sv: expands queued jobs into result items, one per cycle while
// the output is not stalled, into the output register. Depends on upe_pkg.
module upe_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  upe_pkg::t_job i_job,
    output logic          o_pop,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output logic [7:0]    o_out_char,
    output logic [15:0]   o_required_length,
    output logic [1:0]    o_status,
    output logic          o_last
);

    logic [1:0]       r_step, n_step;
    logic             r_valid, n_valid;
    logic [7:0]       r_char, n_char;
    logic [15:0]      r_req, n_req;
    upe_pkg::t_status r_status, n_status;
    logic             r_last, n_last;

    logic       load;
    logic [2:0] nch;
    logic [2:0] total;
    logic       final_item;

    always_comb begin
        unique case (i_job.emit)
            upe_pkg::EMIT_LIT: nch = 3'd1;
            upe_pkg::EMIT_ESC: nch = 3'd3;
            default:           nch = 3'd0;
        endcase
        total      = nch + {2'd0, i_job.tail};
        final_item = ({1'b0, r_step} == total - 3'd1);
        load       = i_job_valid && (!r_valid || i_out_ready);
        o_pop      = load && final_item;

        n_step   = r_step;
        n_valid  = r_valid;
        n_char   = r_char;
        n_req    = r_req;
        n_status = r_status;
        n_last   = r_last;

        if (load) begin
            n_valid = 1'b1;
            n_step  = final_item ? 2'd0 : r_step + 2'd1;
            if ({1'b0, r_step} < nch) begin
                n_req    = 16'd0;
                n_status = upe_pkg::ST_OK;
                n_last   = 1'b0;
                if (i_job.emit == upe_pkg::EMIT_LIT) begin
                    n_char = i_job.data;
                end else begin
                    unique case (r_step)
                        2'd0:    n_char = 8'h25;
                        2'd1:    n_char = upe_pkg::hex_digit(i_job.data[7:4]);
                        default: n_char = upe_pkg::hex_digit(i_job.data[3:0]);
                    endcase
                end
            end else begin
                n_char   = 8'd0;
                n_req    = i_job.req;
                n_status = i_job.status;
                n_last   = 1'b1;
            end
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            r_step  <= n_step;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char   <= n_char;
        r_req    <= n_req;
        r_status <= n_status;
        r_last   <= n_last;
    end

    assign o_out_valid       = r_valid;
    assign o_out_char        = r_char;
    assign o_required_length = r_req;
    assign o_status          = r_status;
    assign o_last            = r_last;

endmodule

// ----- rtl/core/upe_checker.sv -----
// upe_checker.sv: port-level assertions on the percent encoder, bound to it.
// Depends on upe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module upe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  o_out_char,
    input logic [15:0] o_required_length,
    input logic [1:0]  o_status,
    input logic        o_last
);

    // stalled result holds
    `UPE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_char) && $stable(o_last))

    // an error always closes the string
    `UPE_ASSERT_IMP(a_err_last, i_clk, i_rst_n, o_out_valid && o_status != upe_pkg::ST_OK, o_last)

    // error results carry no character
    `UPE_ASSERT_IMP(a_err_char, i_clk, i_rst_n, o_out_valid && o_status != upe_pkg::ST_OK, o_out_char == 8'd0)

    // length only appears on the closing result
    `UPE_ASSERT_IMP(a_len_tail, i_clk, i_rst_n, o_out_valid && !o_last, o_required_length == 16'd0 && o_status == upe_pkg::ST_OK)

endmodule

bind utf8_percent_encoder upe_checker u_upe_checker (.*);

// ----- test/tb_utf8_percent_encoder.sv -----
// tb_utf8_percent_encoder.sv: self-checking testbench of the UTF-8 percent encoder.
// Directed and random strings with random idling on both channels, checked
// against a behavioral predictor. Depends on upe_pkg and utf8_percent_encoder.
module tb_utf8_percent_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    // cycles allowed for a byte that yields no result to finish in the pipeline
    localparam int DRAIN_CYCLES = 16;
    // minimum number of bytes the random part sends in each configuration phase
    localparam int PHASE_BYTES = 28;
    // characters that are kept in at least one of the two modes
    localparam string KEEP_CHARS = "azAZ09-._~:=[]?&%";

    typedef logic [7:0] t_bytes[$];

    // one output transaction as the encoder should produce it
    typedef struct packed {
        logic [7:0]       ch;
        logic [15:0]      len;
        upe_pkg::t_status st;
        logic             last;
    } t_encoded;

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [upe_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [upe_pkg::CFG_WIDTH-1:0] i_cfg_data;
    logic                          i_in_valid;
    logic                          o_in_ready;
    logic [7:0]                    i_in_byte;
    logic                          i_is_last;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    logic [7:0]                    o_out_char;
    logic [15:0]                   o_required_length;
    logic [1:0]                    o_status;
    logic                          o_last;

    utf8_percent_encoder u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_in_byte         (i_in_byte),
        .i_is_last         (i_is_last),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_out_char        (o_out_char),
        .o_required_length (o_required_length),
        .o_status          (o_status),
        .o_last            (o_last)
    );

    // 8 ns period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Encoder predictor: mirror of the register set and per-string state
    // ------------------------------------------------------------------
    logic        cfg_keep_url;
    logic        cfg_measure;
    logic [15:0] cfg_capacity;

    logic [1:0]  cont_left;     // continuation bytes still due in this character
    logic [15:0] cap_left;      // output space left in write mode
    logic [15:0] len_count;     // measure-mode length so far, saturating
    logic        err_latched;   // string already failed, drop until its last byte
    logic        str_started;   // a byte of the current string was taken

    t_encoded    encoded_q[$];  // expected output transactions, oldest first
    int          err_count = 0;
    bit          idle_on = 1'b1; // random gaps on both sides when set

    function automatic bit char_kept(input logic [7:0] c);
        if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9"))
            return 1'b1;
        if (c == "-" || c == "." || c == "_" || c == "~")
            return 1'b1;
        // extended URL set only when enabled
        if (cfg_keep_url && (c == ":" || c == "=" || c == "[" || c == "]" ||
                             c == "?" || c == "&" || c == "%"))
            return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        return (v < 4'd10) ? 8'("0") + 8'(v) : 8'("A") + 8'(v) - 8'd10;
    endfunction

    task automatic end_of_string();
        cont_left   = 2'd0;
        cap_left    = cfg_capacity;
        len_count   = 16'd0;
        err_latched = 1'b0;
        str_started = 1'b0;
    endtask

    task automatic reset_model();
        cfg_keep_url = 1'b0;
        cfg_measure  = 1'b0;
        cfg_capacity = 16'hFFFF;
        end_of_string();
    endtask

    task automatic push_result(input logic [7:0] ch, input logic [15:0] len,
                               input upe_pkg::t_status st, input logic last);
        t_encoded r;
        r.ch   = ch;
        r.len  = len;
        r.st   = st;
        r.last = last;
        encoded_q.push_back(r);
    endtask

    task automatic push_escape(input logic [7:0] b);
        push_result("%", 16'd0, upe_pkg::ST_OK, 1'b0);
        push_result(hex_char(b[7:4]), 16'd0, upe_pkg::ST_OK, 1'b0);
        push_result(hex_char(b[3:0]), 16'd0, upe_pkg::ST_OK, 1'b0);
    endtask

    // a failing string closes with one status result, then drops bytes
    task automatic abort_string(input upe_pkg::t_status code, input logic lst);
        push_result(8'h00, 16'd0, code, 1'b1);
        err_latched = 1'b1;
        if (lst)
            end_of_string();
    endtask

    // predicts the output transactions caused by one accepted byte
    task automatic encode_byte(input logic [7:0] b, input logic lst);
        int unsigned n;
        int unsigned cost;
        logic        keep;
        logic [16:0] sum;
        if (err_latched) begin
            if (lst)
                end_of_string();
            return;
        end
        str_started = 1'b1;
        if (cont_left == 2'd0) begin
            // lead byte: classify the sequence length
            if (b < 8'h80)
                n = 1;
            else if ((b & 8'hE0) == 8'hC0)
                n = 2;
            else if ((b & 8'hF0) == 8'hE0)
                n = 3;
            else if ((b & 8'hF8) == 8'hF0)
                n = 4;
            else begin
                abort_string(upe_pkg::ST_INVALID, lst);
                return;
            end
            keep = (n == 1) && char_kept(b);
            cost = keep ? 1 : 3 * n;
            // whole character must fit with room left for the terminator
            if (!cfg_measure && cost >= cap_left) begin
                abort_string(upe_pkg::ST_NO_SPACE, lst);
                return;
            end
            if (n > 1 && lst) begin
                abort_string(upe_pkg::ST_TRUNC, lst);
                return;
            end
            if (cfg_measure) begin
                sum = 17'(len_count) + 17'(cost);
                len_count = (sum > 17'hFFFF) ? 16'hFFFF : sum[15:0];
            end else begin
                cap_left = cap_left - 16'(cost);
                if (keep)
                    push_result(b, 16'd0, upe_pkg::ST_OK, 1'b0);
                else
                    push_escape(b);
            end
            cont_left = 2'(n - 1);
        end else begin
            // continuation byte: never checked, escaped in write mode
            cont_left = cont_left - 2'd1;
            if (cont_left != 2'd0 && lst) begin
                abort_string(upe_pkg::ST_TRUNC, lst);
                return;
            end
            if (!cfg_measure)
                push_escape(b);
        end
        if (lst) begin
            if (cfg_measure) begin
                sum = 17'(len_count) + 17'd1;
                push_result(8'h00, (sum > 17'hFFFF) ? 16'hFFFF : sum[15:0],
                            upe_pkg::ST_OK, 1'b1);
            end else begin
                push_result(8'h00, 16'd0, upe_pkg::ST_OK, 1'b1);
            end
            end_of_string();
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: random stalls and checking of each transaction
    // ------------------------------------------------------------------
    int unsigned stall_left = 0;

    task automatic check_result();
        t_encoded e;
        if (encoded_q.size() == 0) begin
            $display("%0t: unexpected transaction char %02h len %0d status %0d last %0b",
                     $time, o_out_char, o_required_length, o_status, o_last);
            err_count++;
            return;
        end
        e = encoded_q.pop_front();
        if (o_out_char !== e.ch) begin
            $display("%0t: out_char expected %02h actual %02h", $time, e.ch, o_out_char);
            err_count++;
        end
        if (o_required_length !== e.len) begin
            $display("%0t: required_length expected %0d actual %0d",
                     $time, e.len, o_required_length);
            err_count++;
        end
        if (o_status !== e.st) begin
            $display("%0t: status expected %0d actual %0d", $time, e.st, o_status);
            err_count++;
        end
        if (o_last !== e.last) begin
            $display("%0t: last expected %0b actual %0b", $time, e.last, o_last);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                check_result();
                // fresh stall drawn for every accepted transaction
                stall_left = idle_on ? $urandom_range(0, 10) : 0;
            end else if (stall_left > 0) begin
                stall_left--;
            end
            i_out_ready <= (stall_left == 0);
        end
    end

    // ------------------------------------------------------------------
    // Input side and register writes
    // ------------------------------------------------------------------

    // one input transaction; valid stays up when the next byte has no gap
    task automatic send_byte(input logic [7:0] b, input logic lst);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        i_is_last  <= lst;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        encode_byte(b, lst);
    endtask

    task automatic send_string(input t_bytes s);
        foreach (s[i])
            send_byte(s[i], i == s.size() - 1);
    endtask

    // wait for every expected transaction, then let silent bytes drain
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (encoded_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // writes all three registers back to back; only called while drained
    task automatic set_config(input logic keep, input logic meas, input logic [15:0] cap);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= upe_pkg::CFG_KEEP_URL;
        i_cfg_data  <= upe_pkg::CFG_WIDTH'(keep);
        @(posedge i_clk);
        cfg_keep_url = keep;
        i_cfg_index <= upe_pkg::CFG_MEASURE;
        i_cfg_data  <= upe_pkg::CFG_WIDTH'(meas);
        @(posedge i_clk);
        cfg_measure = meas;
        i_cfg_index <= upe_pkg::CFG_CAPACITY;
        i_cfg_data  <= cap;
        @(posedge i_clk);
        cfg_capacity = cap;
        // a capacity write mid-string does not refill the budget
        if (!str_started)
            cap_left = cap;
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // letters and digits at their range ends and '~' are copied, others escaped
    task automatic test_ascii_literals();
        set_config(1'b0, 1'b0, 16'hFFFF);
        send_string('{"A", "z", "0", "9", "~", ":", 8'h00, 8'h7F});
        wait_drained();
    endtask

    // extended URL set keeps reserved characters that are escaped otherwise
    task automatic test_url_set();
        set_config(1'b1, 1'b0, 16'hFFFF);
        send_string('{":", "%", "["});
        wait_drained();
    endtask

    // two-byte and four-byte characters, the latter at the top of the range
    task automatic test_multibyte();
        set_config(1'b0, 1'b0, 16'hFFFF);
        send_string('{8'hC3, 8'hA9, 8'hF4, 8'h8F, 8'hBF, 8'hBF});
        wait_drained();
    endtask

    // invalid lead with dropped tail, invalid lead on the last byte,
    // string cut inside a character and a multi-byte lead flagged last
    task automatic test_lead_errors();
        send_string('{8'hFF, "a", "b"});
        send_string('{8'h80});
        send_string('{8'hE2, 8'h82});
        send_string('{8'hC3});
        wait_drained();
    endtask

    // no room at all, then room for one character but not the next
    task automatic test_capacity_limit();
        set_config(1'b0, 1'b0, 16'd0);
        send_string('{"a"});
        wait_drained();
        set_config(1'b0, 1'b0, 16'd2);
        send_string('{"a", "b"});
        wait_drained();
    endtask

    // measure mode: only a length at the end, truncation still reported,
    // capacity not consulted
    task automatic test_measure_mode();
        set_config(1'b0, 1'b1, 16'hFFFF);
        send_string('{"a", 8'hC3, 8'hA9, "+"});
        send_string('{8'hE2});
        wait_drained();
        set_config(1'b0, 1'b1, 16'd0);
        send_string('{"a"});
        wait_drained();
    endtask

    // register writes between bytes of one string
    task automatic test_mid_string_writes();
        set_config(1'b0, 1'b0, 16'hFFFF);
        send_byte("x", 1'b0);
        wait_drained();
        set_config(1'b0, 1'b0, 16'd3);      // started: budget kept
        send_byte("+", 1'b1);
        send_string('{"+"});                // fresh budget of 3 is too small
        wait_drained();
        set_config(1'b0, 1'b0, 16'hFFFF);
        send_byte("a", 1'b0);
        wait_drained();
        set_config(1'b0, 1'b1, 16'hFFFF);   // switch to measuring mid-string
        send_byte("b", 1'b1);
        wait_drained();
    endtask

    // mostly well-formed strings with random content over several settings,
    // with some strings cut short or corrupted
    task automatic test_random_strings();
        t_bytes      s;
        int unsigned sent;
        int unsigned nchars;
        int unsigned kind;
        int unsigned n;
        logic [15:0] cap;
        logic        meas;
        for (int ph = 0; ph < 6; ph++) begin
            idle_on = (ph != 2);
            case (ph)
                0:       cap = 16'hFFFF;
                1:       cap = 16'($urandom_range(5, 60));
                2:       cap = 16'hFFFF;
                3:       cap = 16'd0;
                4:       cap = 16'($urandom_range(1, 30));
                default: cap = 16'($urandom_range(0, 65535));
            endcase
            meas = (ph == 3 || ph == 5) ? 1'b1 : ($urandom_range(0, 3) == 0);
            set_config(1'($urandom_range(0, 1)), meas, cap);
            sent = 0;
            while (sent < PHASE_BYTES) begin
                s.delete();
                nchars = $urandom_range(1, 8);
                for (int c = 0; c < nchars; c++) begin
                    kind = $urandom_range(0, 99);
                    if (kind < 30) begin
                        s.push_back(KEEP_CHARS[$urandom_range(0, KEEP_CHARS.len() - 1)]);
                    end else if (kind < 60) begin
                        s.push_back(8'($urandom_range(0, 127)));
                    end else begin
                        n = (kind < 80) ? 2 : (kind < 92) ? 3 : 4;
                        case (n)
                            2:       s.push_back(8'hC0 | 8'($urandom_range(0, 31)));
                            3:       s.push_back(8'hE0 | 8'($urandom_range(0, 15)));
                            default: s.push_back(8'hF0 | 8'($urandom_range(0, 7)));
                        endcase
                        // continuation content is not checked, so any byte will do
                        for (int k = 1; k < n; k++)
                            s.push_back(($urandom_range(0, 7) == 0) ?
                                        8'($urandom_range(0, 255)) :
                                        8'h80 | 8'($urandom_range(0, 63)));
                    end
                end
                kind = $urandom_range(0, 99);
                if (kind < 8) begin
                    // cut the string at a random byte
                    while (s.size() > 1 && s.size() > $urandom_range(1, s.size()))
                        void'(s.pop_back());
                end else if (kind < 16) begin
                    s[$urandom_range(0, s.size() - 1)] = 8'($urandom_range(0, 255));
                end
                send_string(s);
                sent += s.size();
            end
            wait_drained();
        end
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= upe_pkg::CFG_KEEP_URL;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_in_byte   <= 8'h00;
        i_is_last   <= 1'b0;
        reset_model();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_ascii_literals();
        test_url_set();
        test_multibyte();
        test_lead_errors();
        test_capacity_limit();
        test_measure_mode();
        test_mid_string_writes();
        test_random_strings();

        wait_drained();
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
